FILE: hw/rtl/srx_pkg.sv
// Shared types, codes and constants for the SLIP-style frame receiver.
// Used by srx_decode, srx_out_reg and slip_style_frame_receiver; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srx_pkg;

	localparam int MAX_FRAME_BYTES = 1024;

	localparam int BYTE_W = 8;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LIM_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
	localparam int MODE_W = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	localparam logic [BYTE_W-1:0] SYM_START = 8'hC0;
	localparam logic [BYTE_W-1:0] SYM_END   = 8'hC1;
	localparam logic [BYTE_W-1:0] SYM_ESC   = 8'hC2;
	localparam logic [BYTE_W-1:0] ESC_START = 8'hCA;
	localparam logic [BYTE_W-1:0] ESC_END   = 8'hCB;
	localparam logic [BYTE_W-1:0] ESC_ESC   = 8'hCC;

	localparam logic [MODE_W-1:0] MODE_HUNT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ESC   = 2'd2;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] value;
		logic [IDX_W-1:0]  length;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  count;
		logic              has_result;
		result_t           result;
	} decode_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srx_decode.sv
// Next-state and result logic for one received byte.
// Depends on srx_pkg for codes, widths and the decode_t/result_t structs.
`timescale 1ns / 1ps
`default_nettype none

module srx_decode (
	input  wire logic [srx_pkg::MODE_W-1:0] mode,
	input  wire logic [srx_pkg::CNT_W-1:0]  count,
	input  wire logic [srx_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [srx_pkg::CFG_W-1:0]  max_frame_size,
	output srx_pkg::decode_t                dec
);

	logic [srx_pkg::LIM_W-1:0]  lim;
	logic [srx_pkg::LIM_W-1:0]  cfg_ext;
	logic [srx_pkg::CNT_W-1:0]  count_inc;
	logic                       at_limit;
	logic                       is_emit;
	logic [srx_pkg::BYTE_W-1:0] emit_value;

	// saturate the limit at the largest supported frame
	assign cfg_ext = srx_pkg::LIM_W'(max_frame_size);
	assign lim = (cfg_ext > srx_pkg::LIM_W'(srx_pkg::MAX_FRAME_BYTES))
		? srx_pkg::LIM_W'(srx_pkg::MAX_FRAME_BYTES) : cfg_ext;

	assign count_inc = count + srx_pkg::CNT_W'(1);
	assign at_limit  = ({1'b0, srx_pkg::LIM_W'(count_inc)} >= {1'b0, lim});

	always_comb begin
		is_emit    = 1'b0;
		emit_value = rx_byte;
		dec        = '0;
		dec.mode   = mode;
		dec.count  = count;
		unique case (mode)
			srx_pkg::MODE_FRAME: begin
				if (rx_byte == srx_pkg::SYM_START) begin
					dec.count = '0;
				end else if (rx_byte == srx_pkg::SYM_END) begin
					dec.mode          = srx_pkg::MODE_HUNT;
					dec.has_result    = 1'b1;
					dec.result.kind   = srx_pkg::KIND_DONE;
					dec.result.length = count[srx_pkg::IDX_W-1:0];
				end else if (rx_byte == srx_pkg::SYM_ESC) begin
					dec.mode = srx_pkg::MODE_ESC;
				end else begin
					is_emit = 1'b1;
				end
			end
			srx_pkg::MODE_ESC: begin
				if (rx_byte == srx_pkg::ESC_START) begin
					is_emit    = 1'b1;
					emit_value = srx_pkg::SYM_START;
				end else if (rx_byte == srx_pkg::ESC_END) begin
					is_emit    = 1'b1;
					emit_value = srx_pkg::SYM_END;
				end else if (rx_byte == srx_pkg::ESC_ESC) begin
					is_emit    = 1'b1;
					emit_value = srx_pkg::SYM_ESC;
				end else begin
					dec.mode = srx_pkg::MODE_HUNT;
				end
			end
			default: begin
				// hunting, and the unused mode code
				if (rx_byte == srx_pkg::SYM_START) begin
					dec.count = '0;
					dec.mode  = srx_pkg::MODE_FRAME;
				end
			end
		endcase

		if (is_emit) begin
			dec.has_result   = 1'b1;
			dec.result.kind  = srx_pkg::KIND_BYTE;
			dec.result.index = count[srx_pkg::IDX_W-1:0];
			dec.result.value = emit_value;
			dec.count        = count_inc;
			dec.mode         = at_limit ? srx_pkg::MODE_HUNT : srx_pkg::MODE_FRAME;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/srx_out_reg.sv
// Output result register for the frame receiver's result channel.
// Depends on srx_pkg for result_t.
`timescale 1ns / 1ps
`default_nettype none

module srx_out_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire srx_pkg::result_t load_data,
	output logic            ready,
	output logic            valid,
	input  wire logic       stall,
	output srx_pkg::result_t data
);

	logic            valid_q;
	srx_pkg::result_t data_q;

	// free when empty or when the held transaction leaves this cycle
	assign ready = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/slip_style_frame_receiver.sv
// Top level of the SLIP-style frame receiver: input register, mode/count state,
// config register. Depends on srx_pkg, srx_decode and srx_out_reg.
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_stall     rx_byte
//   result   out        out_valid / out_stall   event_kind, byte_index, byte_value, frame_length
//   config   in         cfg_wr_en               cfg_wr_data (max_frame_size)
//
// One byte per cycle while in_stall is low: a byte is registered, decoded
// against the mode/count state in the next cycle and its result lands in the
// output register.
// Reset clears the mode to hunting, the count to zero and the limit to 1024.
// A held result stalls the input only when the next byte also makes a result.
`timescale 1ns / 1ps
`default_nettype none

module slip_style_frame_receiver (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [srx_pkg::BYTE_W-1:0] rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            event_kind,
	output logic [srx_pkg::IDX_W-1:0]       byte_index,
	output logic [srx_pkg::BYTE_W-1:0]      byte_value,
	output logic [srx_pkg::IDX_W-1:0]       frame_length,
	input  wire logic                       cfg_wr_en,
	input  wire logic [srx_pkg::CFG_W-1:0]  cfg_wr_data
);

	logic                       valid_s1;
	logic [srx_pkg::BYTE_W-1:0] byte_s1;
	logic [srx_pkg::MODE_W-1:0] mode_q;
	logic [srx_pkg::CNT_W-1:0]  count_q;
	logic [srx_pkg::CFG_W-1:0]  max_frame_size_q;

	srx_pkg::decode_t dec;
	srx_pkg::result_t out_data;
	logic             out_ready;
	logic             advance_s1;
	logic             in_take;

	srx_decode u_decode (
		.mode           (mode_q),
		.count          (count_q),
		.rx_byte        (byte_s1),
		.max_frame_size (max_frame_size_q),
		.dec            (dec)
	);

	// a byte without a result never waits on the output
	assign advance_s1 = valid_s1 && (!dec.has_result || out_ready);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_take    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= srx_pkg::MODE_HUNT;
			count_q <= '0;
		end else if (advance_s1) begin
			mode_q  <= dec.mode;
			count_q <= dec.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_size_q <= srx_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			max_frame_size_q <= cfg_wr_data;
		end
	end

	srx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1 && dec.has_result),
		.load_data (dec.result),
		.ready     (out_ready),
		.valid     (out_valid),
		.stall     (out_stall),
		.data      (out_data)
	);

	assign event_kind   = out_data.kind;
	assign byte_index   = out_data.index;
	assign byte_value   = out_data.value;
	assign frame_length = out_data.length;

endmodule

`default_nettype wire
